// ===== hw/rtl/onb_pkg.sv =====
package onb_pkg;

    // field and datapath widths
    localparam int IN_W   = 32;
    localparam int OUT_W  = 32;
    localparam int NW     = 64;           // normalizer input width
    localparam int FRAC_O = 30;           // fraction bits of a unit axis
    localparam int MW     = FRAC_O;       // prescaled magnitude bits
    localparam int SQW    = 2 * MW + 2;   // sum of three squares
    localparam int RW     = MW + 1;       // square root bits
    localparam int QW     = FRAC_O + 1;   // quotient bits
    localparam int NUMW   = MW + FRAC_O + 1;
    localparam int PW     = 34;           // projection coefficient bits

    // pipeline depths
    localparam int NRM_LAT = 4 + RW + 1 + QW + 1;
    localparam int PRJ_LAT = 4;
    localparam int LAT     = 3 * NRM_LAT + 2 * PRJ_LAT;

    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_O;

    typedef logic signed [NW-1:0]    wide_t;
    typedef logic signed [MW:0]      pre_t;
    typedef logic signed [OUT_W-1:0] axis_t;

    typedef struct packed {
        logic [5:0] rs;
        logic [4:0] ls;
    } shift_t;

    function automatic logic [NW-1:0] mag_of(input wide_t v);
        return v[NW-1] ? NW'(-v) : NW'(v);
    endfunction

    function automatic logic [5:0] msb_pos(input logic [NW-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // shift that puts the leading one at bit MW-1
    function automatic shift_t pre_shift(input logic [NW-1:0] orv);
        logic [5:0] p;
        shift_t     s;
        p = msb_pos(orv);
        if (p >= 6'(MW - 1))
        begin
            s.rs = p - 6'(MW - 1);
            s.ls = '0;
        end
        else
        begin
            s.rs = '0;
            s.ls = 5'(6'(MW - 1) - p);
        end
        return s;
    endfunction

    function automatic logic [MW-1:0] pre_apply(input logic [NW-1:0] mag, input shift_t s);
        logic [NW-1:0] t;
        t = (mag >> s.rs) << s.ls;
        return t[MW-1:0];
    endfunction

    function automatic pre_t pre_sign(input logic [MW-1:0] m, input logic neg);
        return neg ? -pre_t'({1'b0, m}) : pre_t'({1'b0, m});
    endfunction

    // round half away from zero, drop FRAC_O bits
    function automatic wide_t rnd_q(input wide_t v);
        logic [NW-1:0] m;
        m = (mag_of(v) + (NW'(1) << (FRAC_O - 1))) >> FRAC_O;
        return v[NW-1] ? -wide_t'(m) : wide_t'(m);
    endfunction

endpackage

// ===== hw/rtl/onb_nrm.sv =====
module onb_nrm (
    input  logic           clk,
    input  logic           en,
    input  onb_pkg::wide_t vec [3],
    output onb_pkg::axis_t unit [3],
    output logic           zero
);

    typedef struct packed {
        logic [2:0][onb_pkg::MW-1:0] x;
        logic [2:0]                  sg;
        logic                        zr;
    } side_t;

    typedef struct packed {
        logic [onb_pkg::RW-1:0] r;
        logic [onb_pkg::QW-1:0] lo;
        logic [onb_pkg::QW-1:0] q;
    } div_t;

    localparam int SDN = onb_pkg::NRM_LAT - 2;

    logic [onb_pkg::NW-1:0]    am_reg [3];
    logic [2:0]                sa_reg;
    onb_pkg::shift_t           sh_reg;
    logic                      za_reg;
    side_t                     sd_reg [SDN];
    logic [2*onb_pkg::MW-1:0]  sq_reg [3];
    logic [onb_pkg::SQW-1:0]   rem_reg [onb_pkg::RW+1];
    logic [onb_pkg::SQW-1:0]   root_reg [onb_pkg::RW+1];
    div_t                      dv_reg [onb_pkg::QW+1][3];
    logic [onb_pkg::RW-1:0]    ln_reg [onb_pkg::QW];
    onb_pkg::axis_t            unit_reg [3];
    logic                      zero_reg;

    logic [onb_pkg::NW-1:0]    mag_next [3];
    logic [onb_pkg::NW-1:0]    orv;

    // magnitudes and leading one
    always_comb
    begin
        orv = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = onb_pkg::mag_of(vec[i]);
            orv = orv | mag_next[i];
        end
    end

    // prescale, squares and sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                am_reg[i] <= mag_next[i];
                sa_reg[i] <= vec[i][onb_pkg::NW-1];
                sd_reg[0].x[i] <= onb_pkg::pre_apply(am_reg[i], sh_reg);
                sq_reg[i] <= (2*onb_pkg::MW)'(sd_reg[0].x[i]) * (2*onb_pkg::MW)'(sd_reg[0].x[i]);
            end
            sh_reg <= onb_pkg::pre_shift(orv);
            za_reg <= (orv == '0);
            sd_reg[0].sg <= sa_reg;
            sd_reg[0].zr <= za_reg;
            rem_reg[0] <= onb_pkg::SQW'(sq_reg[0]) + onb_pkg::SQW'(sq_reg[1])
                        + onb_pkg::SQW'(sq_reg[2]);
            root_reg[0] <= '0;
            for (int j = 1; j < SDN; j++)
            begin
                sd_reg[j] <= sd_reg[j-1];
            end
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < onb_pkg::RW; k++)
    begin : g_sqrt
        localparam logic [onb_pkg::SQW-1:0] BIT =
            onb_pkg::SQW'(1) << (2 * (onb_pkg::RW - 1 - k));
        logic [onb_pkg::SQW-1:0] trial;
        assign trial = root_reg[k] + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[k] >= trial)
                begin
                    rem_reg[k+1]  <= rem_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
            end
        end
    end

    // divider setup: rounded numerator, top bits preloaded as remainder
    logic [onb_pkg::RW-1:0]   len;
    logic [onb_pkg::NUMW-1:0] num [3];
    always_comb
    begin
        len = root_reg[onb_pkg::RW][onb_pkg::RW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            num[i] = {1'b0, sd_reg[onb_pkg::RW+2].x[i], onb_pkg::FRAC_O'(0)}
                   + onb_pkg::NUMW'(len >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[0][i].r  <= onb_pkg::RW'(num[i][onb_pkg::NUMW-1:onb_pkg::QW]);
                dv_reg[0][i].lo <= num[i][onb_pkg::QW-1:0];
                dv_reg[0][i].q  <= '0;
            end
            ln_reg[0] <= len;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < onb_pkg::QW; k++)
    begin : g_div
        logic [onb_pkg::RW:0] t [3];
        logic                 ge [3];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                t[i]  = {dv_reg[k][i].r, dv_reg[k][i].lo[onb_pkg::QW-1]};
                ge[i] = (t[i] >= {1'b0, ln_reg[k]});
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_reg[k+1][i].r  <= ge[i] ? onb_pkg::RW'(t[i] - {1'b0, ln_reg[k]})
                                               : t[i][onb_pkg::RW-1:0];
                    dv_reg[k+1][i].lo <= dv_reg[k][i].lo << 1;
                    dv_reg[k+1][i].q  <= {dv_reg[k][i].q[onb_pkg::QW-2:0], ge[i]};
                end
            end
        end
        if (k < onb_pkg::QW - 1)
        begin : g_len
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ln_reg[k+1] <= ln_reg[k];
                end
            end
        end
    end

    // clamp, sign and zero vector
    logic [onb_pkg::QW-1:0] qc [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qc[i] = (dv_reg[onb_pkg::QW][i].q > onb_pkg::ONE_Q) ? onb_pkg::ONE_Q
                                                                : dv_reg[onb_pkg::QW][i].q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (sd_reg[SDN-1].zr)
                begin
                    unit_reg[i] <= '0;
                end
                else if (sd_reg[SDN-1].sg[i])
                begin
                    unit_reg[i] <= -onb_pkg::axis_t'(onb_pkg::OUT_W'(qc[i]));
                end
                else
                begin
                    unit_reg[i] <= onb_pkg::axis_t'(onb_pkg::OUT_W'(qc[i]));
                end
            end
            zero_reg <= sd_reg[SDN-1].zr;
        end
    end

    assign unit = unit_reg;
    assign zero = zero_reg;

endmodule

// ===== hw/rtl/orthonormal_basis_3d.sv =====
// Gram-Schmidt orthonormal basis from three 3D vectors.
// Input stream: s_axis_tdata carries vectors A, B, C in signed Q16.16,
// s_axis_tuser selects the third axis (0: from C, 1: cross product of
// the first two, C ignored). Output stream: m_axis_tdata carries unit
// axes U, V, W in signed Q2.30, m_axis_tuser flags a zero-length vector
// met during normalization (that axis comes out as zero).
// The path to m_axis_tvalid runs through three normalizers of 68
// stages each (prescale, sum of squares, a 31-stage square root,
// divider setup, a 31-stage divider, output) plus two 4-stage
// projection units. One transaction is taken per cycle unless stalled.
// The whole pipeline advances on one enable; when the receiver holds
// tready low with a result waiting, every stage and s_axis_tready hold
// until that result is taken, so nothing is dropped or repeated.
// Reset clears all valid bits; data registers are not reset.
module orthonormal_basis_3d (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic         s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [287:0] m_axis_tdata,  // u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z
    output logic         m_axis_tuser   // degenerate
);

    localparam int NL  = onb_pkg::NRM_LAT;
    localparam int LAT = onb_pkg::LAT;
    localparam int IW  = onb_pkg::IN_W;
    localparam int NW  = onb_pkg::NW;
    localparam int PW  = onb_pkg::PW;

    logic en;
    logic [LAT:0] vld_reg;

    // global advance
    assign en            = !vld_reg[LAT] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-1:0], s_axis_tvalid};
        end
    end

    // input stage and prescale of B and C
    logic                   mode_reg;
    onb_pkg::axis_t         a_reg [3];
    onb_pkg::axis_t         b_reg [3];
    onb_pkg::axis_t         c_reg [3];
    logic [IW-1:0]          bm_reg [3];
    logic [IW-1:0]          cm_reg [3];
    logic [2:0]             bs_reg, cs_reg;
    onb_pkg::shift_t        bsh_reg, csh_reg;
    logic [IW-1:0]          bmag [3];
    logic [IW-1:0]          cmag [3];
    logic [IW-1:0]          bor, cor;

    always_comb
    begin
        bor = '0;
        cor = '0;
        for (int i = 0; i < 3; i++)
        begin
            bmag[i] = IW'(onb_pkg::mag_of(NW'(b_reg[i])));
            cmag[i] = IW'(onb_pkg::mag_of(NW'(c_reg[i])));
            bor = bor | bmag[i];
            cor = cor | cmag[i];
        end
    end

    // delay lines, entry j holds the stage just after the feeding one
    localparam int BPN = NL + 2;
    localparam int CPN = 2 * NL + 6;
    localparam int MDN = 2 * NL + 7;
    localparam int UQN = 2 * NL + 8;
    localparam int VQN = NL + 4;

    onb_pkg::pre_t  bpd_reg [BPN][3];
    onb_pkg::pre_t  cpd_reg [CPN][3];
    logic [MDN-1:0] md_reg;
    onb_pkg::axis_t uq_reg [UQN][3];
    onb_pkg::axis_t vq_reg [VQN][3];
    logic [UQN-1:0] za_reg;
    logic [VQN-1:0] zb_reg;

    onb_pkg::axis_t u [3];
    onb_pkg::axis_t v [3];
    onb_pkg::axis_t w [3];
    logic           zu, zv, zw;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg <= s_axis_tuser;
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]  <= s_axis_tdata[IW*i +: IW];
                b_reg[i]  <= s_axis_tdata[IW*(3+i) +: IW];
                c_reg[i]  <= s_axis_tdata[IW*(6+i) +: IW];
                bm_reg[i] <= bmag[i];
                cm_reg[i] <= cmag[i];
                bs_reg[i] <= b_reg[i][IW-1];
                cs_reg[i] <= c_reg[i][IW-1];
                bpd_reg[0][i] <= onb_pkg::pre_sign(
                    onb_pkg::pre_apply(NW'(bm_reg[i]), bsh_reg), bs_reg[i]);
                cpd_reg[0][i] <= onb_pkg::pre_sign(
                    onb_pkg::pre_apply(NW'(cm_reg[i]), csh_reg), cs_reg[i]);
                uq_reg[0][i] <= u[i];
                vq_reg[0][i] <= v[i];
            end
            bsh_reg <= onb_pkg::pre_shift(NW'(bor));
            csh_reg <= onb_pkg::pre_shift(NW'(cor));
            for (int j = 1; j < BPN; j++)
            begin
                bpd_reg[j] <= bpd_reg[j-1];
            end
            for (int j = 1; j < CPN; j++)
            begin
                cpd_reg[j] <= cpd_reg[j-1];
            end
            for (int j = 1; j < UQN; j++)
            begin
                uq_reg[j] <= uq_reg[j-1];
            end
            for (int j = 1; j < VQN; j++)
            begin
                vq_reg[j] <= vq_reg[j-1];
            end
            md_reg <= {md_reg[MDN-2:0], mode_reg};
            za_reg <= {za_reg[UQN-2:0], zu};
            zb_reg <= {zb_reg[VQN-2:0], zv};
        end
    end

    // first axis
    onb_pkg::wide_t a_vec [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_vec[i] = NW'(a_reg[i]);
        end
    end

    onb_nrm u_nrm_a (
        .clk  (clk),
        .en   (en),
        .vec  (a_vec),
        .unit (u),
        .zero (zu)
    );

    // projection of B on the first axis removed
    onb_pkg::wide_t        pb_prod_reg [3];
    logic signed [PW-1:0]  pb_p_reg;
    onb_pkg::wide_t        pb_m_reg [3];
    onb_pkg::wide_t        b2_reg [3];
    onb_pkg::wide_t        pb_dot;
    onb_pkg::wide_t        pb_rnd;

    always_comb
    begin
        pb_dot = pb_prod_reg[0] + pb_prod_reg[1] + pb_prod_reg[2];
        pb_rnd = onb_pkg::rnd_q(pb_dot);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pb_prod_reg[i] <= NW'(bpd_reg[NL-2][i]) * NW'(u[i]);
                pb_m_reg[i]    <= NW'(uq_reg[1][i]) * NW'(pb_p_reg);
                b2_reg[i]      <= NW'(bpd_reg[NL+1][i]) - onb_pkg::rnd_q(pb_m_reg[i]);
            end
            pb_p_reg <= pb_rnd[PW-1:0];
        end
    end

    onb_nrm u_nrm_b (
        .clk  (clk),
        .en   (en),
        .vec  (b2_reg),
        .unit (v),
        .zero (zv)
    );

    // third axis: projections of C removed, or cross product
    onb_pkg::wide_t        pu_reg [3];
    onb_pkg::wide_t        pv_reg [3];
    onb_pkg::wide_t        xa_reg [3];
    onb_pkg::wide_t        xb_reg [3];
    logic signed [PW-1:0]  p1_reg, p2_reg;
    onb_pkg::wide_t        cr_reg [3];
    onb_pkg::wide_t        cr3_reg [3];
    onb_pkg::wide_t        m1_reg [3];
    onb_pkg::wide_t        m2_reg [3];
    onb_pkg::wide_t        w_in_reg [3];
    onb_pkg::wide_t        pc_r1, pc_r2;

    always_comb
    begin
        pc_r1 = onb_pkg::rnd_q(pu_reg[0] + pu_reg[1] + pu_reg[2]);
        pc_r2 = onb_pkg::rnd_q(pv_reg[0] + pv_reg[1] + pv_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pu_reg[i]  <= NW'(cpd_reg[2*NL+2][i]) * NW'(uq_reg[NL+3][i]);
                pv_reg[i]  <= NW'(cpd_reg[2*NL+2][i]) * NW'(v[i]);
                cr_reg[i]  <= xa_reg[i] - xb_reg[i];
                cr3_reg[i] <= cr_reg[i];
                m1_reg[i]  <= NW'(uq_reg[NL+5][i]) * NW'(p1_reg);
                m2_reg[i]  <= NW'(vq_reg[1][i]) * NW'(p2_reg);
                w_in_reg[i] <= md_reg[MDN-1] ? cr3_reg[i]
                             : NW'(cpd_reg[CPN-1][i]) - onb_pkg::rnd_q(m1_reg[i])
                               - onb_pkg::rnd_q(m2_reg[i]);
            end
            xa_reg[0] <= NW'(uq_reg[NL+3][1]) * NW'(v[2]);
            xb_reg[0] <= NW'(uq_reg[NL+3][2]) * NW'(v[1]);
            xa_reg[1] <= NW'(uq_reg[NL+3][2]) * NW'(v[0]);
            xb_reg[1] <= NW'(uq_reg[NL+3][0]) * NW'(v[2]);
            xa_reg[2] <= NW'(uq_reg[NL+3][0]) * NW'(v[1]);
            xb_reg[2] <= NW'(uq_reg[NL+3][1]) * NW'(v[0]);
            p1_reg <= pc_r1[PW-1:0];
            p2_reg <= pc_r2[PW-1:0];
        end
    end

    onb_nrm u_nrm_w (
        .clk  (clk),
        .en   (en),
        .vec  (w_in_reg),
        .unit (w),
        .zero (zw)
    );

    // result transaction
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_axis_tdata[IW*i +: IW]     = uq_reg[UQN-1][i];
            m_axis_tdata[IW*(3+i) +: IW] = vq_reg[VQN-1][i];
            m_axis_tdata[IW*(6+i) +: IW] = w[i];
        end
    end

    assign m_axis_tuser = za_reg[UQN-1] | zb_reg[VQN-1] | zw;

    localparam onb_pkg::axis_t ONE = onb_pkg::axis_t'(onb_pkg::OUT_W'(onb_pkg::ONE_Q));

    // a stalled result freezes the whole pipeline
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT] && !m_axis_tready |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved during output stall");

    // a zero first vector gives a zero first axis
    a_zero_u: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT] && za_reg[UQN-1] |->
        uq_reg[UQN-1][0] == '0 && uq_reg[UQN-1][1] == '0 && uq_reg[UQN-1][2] == '0)
        else $error("degenerate first axis not zero");

    // third axis components stay within plus and minus one
    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT] |-> w[0] <= ONE && w[0] >= -ONE && w[1] <= ONE && w[1] >= -ONE
                         && w[2] <= ONE && w[2] >= -ONE)
        else $error("third axis out of range");

endmodule
